// File: hw/rtl/direct_mapped_write_back_cache_assert.svh
// Assertion macros for the direct-mapped write-back cache.
`ifndef DIRECT_MAPPED_WRITE_BACK_CACHE_ASSERT_SVH
`define DIRECT_MAPPED_WRITE_BACK_CACHE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on clock and cut off by reset.
`define DMC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cache assertion failed");
// Next-cycle implication.
`define DMC_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cache assertion failed");
`else
`define DMC_ASSERT_IMP(lbl, ante, cons)
`define DMC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/dmc_pkg.sv
// Shared codes, widths and types of the direct-mapped write-back cache.
package dmc_pkg;

   localparam int ADDR_W    = 32;
   localparam int DATA_W    = 32;
   localparam int COUNT_W   = 32;
   localparam int BYTE_BITS = 2;

   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_FILL  = 2'd2;

   localparam logic [1:0] KIND_READ     = 2'd0;
   localparam logic [1:0] KIND_WDONE    = 2'd1;
   localparam logic [1:0] KIND_WB       = 2'd2;
   localparam logic [1:0] KIND_FILL_REQ = 2'd3;

   localparam logic [1:0] OUT_HIT      = 2'd0;
   localparam logic [1:0] OUT_COLD     = 2'd1;
   localparam logic [1:0] OUT_CONFLICT = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [ADDR_W-1:0]  mem_address;
      logic [DATA_W-1:0]  word;
      logic [1:0]         outcome;
      logic [COUNT_W-1:0] hit_total;
      logic [COUNT_W-1:0] miss_total;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic clearing;
      logic awaiting;
   } status_type;

endpackage

// File: hw/rtl/dmc_req_if.sv
// Request channel of the cache: accesses and line fill words.
interface dmc_req_if import dmc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        func;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] write_data;
   logic [DATA_W-1:0] fill_word;

   modport source (output valid, func, address, write_data, fill_word, input ready);
   modport sink   (input valid, func, address, write_data, fill_word, output ready);
endinterface

// File: hw/rtl/dmc_rsp_if.sv
// Response channel of the cache: access results, write-back words and fill requests.
interface dmc_rsp_if import dmc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [ADDR_W-1:0]  mem_address;
   logic [DATA_W-1:0]  word;
   logic [1:0]         outcome;
   logic [COUNT_W-1:0] hit_total;
   logic [COUNT_W-1:0] miss_total;
   logic               last;

   modport source (output valid, kind, mem_address, word, outcome, hit_total, miss_total,
                   last, input ready);
   modport sink   (input valid, kind, mem_address, word, outcome, hit_total, miss_total,
                   last, output ready);
endinterface

// File: hw/rtl/direct_mapped_write_back_cache.sv
// Direct-mapped write-back write-allocate cache. LINE_COUNT and WORDS_PER_LINE are powers of two.
// Hit: tag/data RAM read, then compare, then the registered result; no new access is taken
// until the cache is idle again. Dirty miss: WORDS_PER_LINE write-back beats at one per cycle
// while the response channel takes them, then the fill request; fill words are taken one per
// cycle, then the tag is written and a write completes or the read word is fetched and sent.
// Reset: a clearing pass writes every tag entry invalid; req_ch.ready stays low until it ends.
`include "direct_mapped_write_back_cache_assert.svh"

module direct_mapped_write_back_cache import dmc_pkg::*; #(
   parameter int LINE_COUNT     = 128,
   parameter int WORDS_PER_LINE = 16
) (
   input  logic       clock,
   input  logic       reset,
   dmc_req_if.sink    req_ch,
   dmc_rsp_if.source  rsp_ch
);

   localparam int WORD_BITS  = $clog2(WORDS_PER_LINE);
   localparam int INDEX_BITS = $clog2(LINE_COUNT);
   localparam int TAG_BITS   = ADDR_W - BYTE_BITS - WORD_BITS - INDEX_BITS;
   localparam int TAGRAM_W   = TAG_BITS + 2;
   localparam int DATA_DEPTH = LINE_COUNT * WORDS_PER_LINE;
   localparam int DATA_AW    = $clog2(DATA_DEPTH);

   logic                  load, can_load;
   rsp_type               rsp_data;
   status_type            status;
   logic                  t_wr_en, t_rd_en, d_wr_en, d_rd_en;
   logic [INDEX_BITS-1:0] t_wr_addr, t_rd_addr;
   logic [TAGRAM_W-1:0]   t_wr_data, t_rd_data;
   logic [DATA_AW-1:0]    d_wr_addr, d_rd_addr;
   logic [DATA_W-1:0]     d_wr_data, d_rd_data;

   dmc_ram #(.WIDTH(TAGRAM_W), .DEPTH(LINE_COUNT)) u_tag_ram (
      .clock   (clock),
      .wr_en   (t_wr_en),
      .wr_addr (t_wr_addr),
      .wr_data (t_wr_data),
      .rd_en   (t_rd_en),
      .rd_addr (t_rd_addr),
      .rd_data (t_rd_data)
   );

   dmc_ram #(.WIDTH(DATA_W), .DEPTH(DATA_DEPTH)) u_data_ram (
      .clock   (clock),
      .wr_en   (d_wr_en),
      .wr_addr (d_wr_addr),
      .wr_data (d_wr_data),
      .rd_en   (d_rd_en),
      .rd_addr (d_rd_addr),
      .rd_data (d_rd_data)
   );

   dmc_ctrl #(
      .LINE_COUNT     (LINE_COUNT),
      .WORDS_PER_LINE (WORDS_PER_LINE),
      .TAGRAM_W       (TAGRAM_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .can_load  (can_load),
      .load      (load),
      .rsp_data  (rsp_data),
      .status    (status),
      .t_wr_en   (t_wr_en),
      .t_wr_addr (t_wr_addr),
      .t_wr_data (t_wr_data),
      .t_rd_en   (t_rd_en),
      .t_rd_addr (t_rd_addr),
      .t_rd_data (t_rd_data),
      .d_wr_en   (d_wr_en),
      .d_wr_addr (d_wr_addr),
      .d_wr_data (d_wr_data),
      .d_rd_en   (d_rd_en),
      .d_rd_addr (d_rd_addr),
      .d_rd_data (d_rd_data)
   );

   dmc_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .data     (rsp_data),
      .can_load (can_load),
      .rsp      (rsp_ch)
   );

   `DMC_ASSERT_IMP(a_clear_blocks_req, status.clearing, !req_ch.ready)
   `DMC_ASSERT_IMP(a_wb_not_last, rsp_ch.valid && (rsp_ch.kind == KIND_WB), !rsp_ch.last)
   `DMC_ASSERT_IMP(a_fill_req_shown, $rose(status.awaiting),
                   rsp_ch.valid && (rsp_ch.kind == KIND_FILL_REQ) && rsp_ch.last)
   `DMC_ASSERT_NXT(a_no_wb_after_fill_req, $rose(status.awaiting),
                   !rsp_ch.valid || (rsp_ch.kind != KIND_WB))

endmodule

// File: hw/rtl/dmc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module dmc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/dmc_out_reg.sv
// Output register of the cache response channel.
module dmc_out_reg import dmc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_type      data,
   output logic         can_load,
   dmc_rsp_if.source    rsp
);

   logic    valid_ff, valid_in;
   rsp_type data_ff,  data_in;

   assign can_load = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = data;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.kind        = data_ff.kind;
   assign rsp.mem_address = data_ff.mem_address;
   assign rsp.word        = data_ff.word;
   assign rsp.outcome     = data_ff.outcome;
   assign rsp.hit_total   = data_ff.hit_total;
   assign rsp.miss_total  = data_ff.miss_total;
   assign rsp.last        = data_ff.last;

endmodule

// File: hw/rtl/dmc_ctrl.sv
// Cache controller: lookup, write-back, fill and tag clearing sequencer.
module dmc_ctrl import dmc_pkg::*; #(
   parameter int LINE_COUNT     = 128,
   parameter int WORDS_PER_LINE = 16,
   parameter int TAGRAM_W       = 21
) (
   input  logic                                        clock,
   input  logic                                        reset,
   dmc_req_if.sink                                     req,
   input  logic                                        can_load,
   output logic                                        load,
   output rsp_type                                     rsp_data,
   output status_type                                  status,
   output logic                                        t_wr_en,
   output logic [$clog2(LINE_COUNT)-1:0]               t_wr_addr,
   output logic [TAGRAM_W-1:0]                         t_wr_data,
   output logic                                        t_rd_en,
   output logic [$clog2(LINE_COUNT)-1:0]               t_rd_addr,
   input  logic [TAGRAM_W-1:0]                         t_rd_data,
   output logic                                        d_wr_en,
   output logic [$clog2(LINE_COUNT*WORDS_PER_LINE)-1:0] d_wr_addr,
   output logic [DATA_W-1:0]                           d_wr_data,
   output logic                                        d_rd_en,
   output logic [$clog2(LINE_COUNT*WORDS_PER_LINE)-1:0] d_rd_addr,
   input  logic [DATA_W-1:0]                           d_rd_data
);

   localparam int WORD_BITS  = $clog2(WORDS_PER_LINE);
   localparam int INDEX_BITS = $clog2(LINE_COUNT);
   localparam int IDX_LSB    = BYTE_BITS + WORD_BITS;
   localparam int TAG_LSB    = IDX_LSB + INDEX_BITS;
   localparam int TAG_BITS   = ADDR_W - TAG_LSB;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_LOOKUP = 3'd2;
   localparam logic [2:0] ST_WB     = 3'd3;
   localparam logic [2:0] ST_FREQ   = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;
   localparam logic [2:0] ST_RESP   = 3'd6;

   localparam logic [WORD_BITS-1:0]  LAST_WORD = WORD_BITS'(WORDS_PER_LINE - 1);
   localparam logic [INDEX_BITS-1:0] LAST_LINE = INDEX_BITS'(LINE_COUNT - 1);

   logic [2:0]            state_ff,    state_in;
   logic [INDEX_BITS-1:0] clr_cnt_ff,  clr_cnt_in;
   logic                  awaiting_ff, awaiting_in;
   logic                  pend_wr_ff,  pend_wr_in;
   logic [ADDR_W-1:0]     pend_addr_ff, pend_addr_in;
   logic [DATA_W-1:0]     pend_data_ff, pend_data_in;
   logic [1:0]            outcome_ff,  outcome_in;
   logic [WORD_BITS-1:0]  fill_pos_ff, fill_pos_in;
   logic [WORD_BITS-1:0]  wb_cnt_ff,   wb_cnt_in;
   logic [COUNT_W-1:0]    hits_ff,     hits_in;
   logic [COUNT_W-1:0]    misses_ff,   misses_in;

   logic [WORD_BITS-1:0]  p_word, r_word;
   logic [INDEX_BITS-1:0] p_idx,  r_idx;
   logic [TAG_BITS-1:0]   p_tag,  t_tag;
   logic                  t_valid, t_dirty, hit, accept, is_access;

   assign p_word  = pend_addr_ff[IDX_LSB-1:BYTE_BITS];
   assign p_idx   = pend_addr_ff[TAG_LSB-1:IDX_LSB];
   assign p_tag   = pend_addr_ff[ADDR_W-1:TAG_LSB];
   assign r_word  = req.address[IDX_LSB-1:BYTE_BITS];
   assign r_idx   = req.address[TAG_LSB-1:IDX_LSB];
   assign t_valid = t_rd_data[TAGRAM_W-1];
   assign t_dirty = t_rd_data[TAGRAM_W-2];
   assign t_tag   = t_rd_data[TAG_BITS-1:0];
   assign hit     = t_valid && (t_tag == p_tag);

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign is_access = (req.func == FUNC_READ) || (req.func == FUNC_WRITE);

   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.awaiting = awaiting_ff;

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      awaiting_in  = awaiting_ff;
      pend_wr_in   = pend_wr_ff;
      pend_addr_in = pend_addr_ff;
      pend_data_in = pend_data_ff;
      outcome_in   = outcome_ff;
      fill_pos_in  = fill_pos_ff;
      wb_cnt_in    = wb_cnt_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;

      t_wr_en   = 1'b0;
      t_wr_addr = p_idx;
      t_wr_data = {1'b1, pend_wr_ff, p_tag};
      t_rd_en   = 1'b0;
      t_rd_addr = r_idx;
      d_wr_en   = 1'b0;
      d_wr_addr = {p_idx, p_word};
      d_wr_data = pend_data_ff;
      d_rd_en   = 1'b0;
      d_rd_addr = {r_idx, r_word};

      load                 = 1'b0;
      rsp_data.kind        = KIND_READ;
      rsp_data.mem_address = '0;
      rsp_data.word        = '0;
      rsp_data.outcome     = outcome_ff;
      rsp_data.hit_total   = hits_ff;
      rsp_data.miss_total  = misses_ff;
      rsp_data.last        = 1'b1;

      unique case (state_ff)
         ST_CLEAR: begin
            t_wr_en    = 1'b1;
            t_wr_addr  = clr_cnt_ff;
            t_wr_data  = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_LINE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && is_access && !awaiting_ff) begin
               t_rd_en      = 1'b1;
               d_rd_en      = 1'b1;
               pend_wr_in   = (req.func == FUNC_WRITE);
               pend_addr_in = req.address;
               pend_data_in = req.write_data;
               state_in     = ST_LOOKUP;
            end else if (accept && (req.func == FUNC_FILL) && awaiting_ff) begin
               d_wr_en     = 1'b1;
               d_wr_addr   = {p_idx, fill_pos_ff};
               d_wr_data   = req.fill_word;
               fill_pos_in = fill_pos_ff + 1'b1;
               if (fill_pos_ff == LAST_WORD) begin
                  state_in = ST_FINISH;
               end
            end
            // anything else is out of place: drop the beat
         end
         ST_LOOKUP: begin
            if (hit) begin
               if (can_load) begin
                  load                = 1'b1;
                  hits_in             = hits_ff + 1'b1;
                  rsp_data.outcome    = OUT_HIT;
                  rsp_data.hit_total  = hits_ff + 1'b1;
                  if (pend_wr_ff) begin
                     rsp_data.kind = KIND_WDONE;
                     d_wr_en       = 1'b1;
                     t_wr_en       = 1'b1;
                     t_wr_data     = {1'b1, 1'b1, p_tag};
                  end else begin
                     rsp_data.kind = KIND_READ;
                     rsp_data.word = d_rd_data;
                  end
                  state_in = ST_IDLE;
               end
            end else begin
               misses_in  = misses_ff + 1'b1;
               outcome_in = t_valid ? OUT_CONFLICT : OUT_COLD;
               if (t_valid && t_dirty) begin
                  d_rd_en   = 1'b1;
                  d_rd_addr = {p_idx, {WORD_BITS{1'b0}}};
                  wb_cnt_in = '0;
                  state_in  = ST_WB;
               end else begin
                  state_in = ST_FREQ;
               end
            end
         end
         ST_WB: begin
            // tag read data still holds the victim line
            if (can_load) begin
               load                 = 1'b1;
               rsp_data.kind        = KIND_WB;
               rsp_data.mem_address = {t_tag, p_idx, wb_cnt_ff, {BYTE_BITS{1'b0}}};
               rsp_data.word        = d_rd_data;
               rsp_data.last        = 1'b0;
               if (wb_cnt_ff == LAST_WORD) begin
                  state_in = ST_FREQ;
               end else begin
                  wb_cnt_in = wb_cnt_ff + 1'b1;
                  d_rd_en   = 1'b1;
                  d_rd_addr = {p_idx, wb_cnt_ff + 1'b1};
               end
            end
         end
         ST_FREQ: begin
            if (can_load) begin
               load                 = 1'b1;
               rsp_data.kind        = KIND_FILL_REQ;
               rsp_data.mem_address = {p_tag, p_idx, {IDX_LSB{1'b0}}};
               awaiting_in          = 1'b1;
               fill_pos_in          = '0;
               state_in             = ST_IDLE;
            end
         end
         ST_FINISH: begin
            t_wr_en = 1'b1;
            if (pend_wr_ff) begin
               if (can_load) begin
                  d_wr_en       = 1'b1;
                  load          = 1'b1;
                  rsp_data.kind = KIND_WDONE;
                  awaiting_in   = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else begin
               d_rd_en   = 1'b1;
               d_rd_addr = {p_idx, p_word};
               state_in  = ST_RESP;
            end
         end
         ST_RESP: begin
            if (can_load) begin
               load          = 1'b1;
               rsp_data.kind = KIND_READ;
               rsp_data.word = d_rd_data;
               awaiting_in   = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_cnt_ff  <= '0;
         awaiting_ff <= 1'b0;
         pend_wr_ff  <= 1'b0;
         outcome_ff  <= OUT_HIT;
         fill_pos_ff <= '0;
         wb_cnt_ff   <= '0;
         hits_ff     <= '0;
         misses_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         clr_cnt_ff  <= clr_cnt_in;
         awaiting_ff <= awaiting_in;
         pend_wr_ff  <= pend_wr_in;
         outcome_ff  <= outcome_in;
         fill_pos_ff <= fill_pos_in;
         wb_cnt_ff   <= wb_cnt_in;
         hits_ff     <= hits_in;
         misses_ff   <= misses_in;
      end
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
   end

endmodule
